[hw/rtl/assert_macros.svh]
// Assertion macros used by the light average fire detector RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LAFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true outside reset.
`define LAFD_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[hw/rtl/lafd_pkg.sv]
// Types and constants of the light average fire detector
`default_nettype none

package lafd_pkg;

    localparam int LIGHT_W = 12;
    localparam int TEMP_W  = 12;
    localparam int TIME_W  = 32;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // front queue depth, in beats
    localparam int QUEUE_DEPTH = 2;

    // input command codes
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_LIGHT_THR = 2'd0;
    localparam logic [1:0] REG_TEMP_THR  = 2'd1;
    localparam logic [1:0] REG_HOLD_TIME = 2'd2;

    localparam logic [LIGHT_W-1:0] LIGHT_THR_RESET = 12'd3000;
    localparam logic [TEMP_W-1:0]  TEMP_THR_RESET  = 12'd800;
    localparam logic [TIME_W-1:0]  HOLD_TIME_RESET = 32'd5000;

    typedef struct packed {
        logic                     command;
        logic [LIGHT_W-1:0]       light_sample;
        logic signed [TEMP_W-1:0] temperature;
        logic                     temp_valid;
        logic [TIME_W-1:0]        now_ms;
    } in_t;

    typedef struct packed {
        logic               fire;
        logic [LIGHT_W-1:0] light_mean;
    } out_t;

    typedef enum logic {
        OP_STORE,
        OP_EVAL
    } op_kind_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic [LIGHT_W-1:0]       light_sample;
        logic signed [TEMP_W-1:0] temperature;
        logic                     temp_valid;
        logic [TIME_W-1:0]        now_ms;
    } op_t;

    typedef struct packed {
        logic [LIGHT_W-1:0]       light_threshold;
        logic signed [TEMP_W-1:0] temp_threshold;
        logic [TIME_W-1:0]        hold_time_ms;
    } cfg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_STORE_RD,
        B_STORE_WR,
        B_DIV,
        B_DECIDE
    } back_state_t;

endpackage

`default_nettype wire

[hw/rtl/lafd_front.sv]
// Front part: accepts input beats, decodes the command, queues operations
`default_nettype none

module lafd_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire lafd_pkg::in_t  in_data,
    output logic                op_valid,
    input  wire logic           op_ready,
    output lafd_pkg::op_t       op
);
    import lafd_pkg::*;

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    op_t              queue_reg [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    op_t              op_in;
    logic             push;
    logic             pop;

    always_comb
    begin
        op_in.kind         = (in_data.command == CMD_EVAL) ? OP_EVAL : OP_STORE;
        op_in.light_sample = in_data.light_sample;
        op_in.temperature  = in_data.temperature;
        op_in.temp_valid   = in_data.temp_valid;
        op_in.now_ms       = in_data.now_ms;
    end

    assign in_ready = (count_reg != QCW'(QUEUE_DEPTH));
    assign op_valid = (count_reg != '0);
    assign op       = queue_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = op_valid && op_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lafd_back.sv]
// Back part: sample window, running sum, serial divider, fire decision
`default_nettype none
`include "assert_macros.svh"

module lafd_back #(
    parameter int WINDOW_DEPTH = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           op_valid,
    output logic                op_ready,
    input  wire lafd_pkg::op_t  op,
    input  wire lafd_pkg::cfg_t cfg,
    output logic                out_valid,
    input  wire logic           out_ready,
    output lafd_pkg::out_t      out_data
);
    import lafd_pkg::*;

    localparam int PW  = $clog2(WINDOW_DEPTH);
    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int SW  = LIGHT_W + PW;
    localparam int SCW = $clog2(SW);

    logic [LIGHT_W-1:0] sample_mem [WINDOW_DEPTH];
    logic [LIGHT_W-1:0] rd_data_reg;

    back_state_t        state_reg, state_next;
    op_t                op_reg, op_next;
    logic [PW-1:0]      wp_reg, wp_next;
    logic               full_reg, full_next;
    logic [SW-1:0]      sum_reg, sum_next;
    logic [TIME_W-1:0]  last_fire_reg, last_fire_next;
    logic [SW-1:0]      dvd_reg, dvd_next;
    logic [CW:0]        rem_reg, rem_next;
    logic [SW-1:0]      quo_reg, quo_next;
    logic [SCW-1:0]     step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_data_reg, out_data_next;

    logic [CW-1:0]      win_count;
    logic [CW:0]        rem_sh;
    logic               rem_ge;
    logic               mem_we;
    logic               out_load;
    logic [TIME_W-1:0]  elapsed;
    logic               light_hi;
    logic               temp_hi;
    logic               hit;
    logic               held;

    assign win_count = full_reg ? CW'(WINDOW_DEPTH) : CW'(wp_reg);

    // one restoring division step per cycle
    assign rem_sh = {rem_reg[CW-1:0], dvd_reg[SW-1]};
    assign rem_ge = (rem_sh >= {1'b0, win_count});

    assign light_hi = (quo_reg[LIGHT_W-1:0] >= cfg.light_threshold);
    assign temp_hi  = ($signed(op_reg.temperature) >= $signed(cfg.temp_threshold));
    assign elapsed  = op_reg.now_ms - last_fire_reg;
    assign hit      = op_reg.temp_valid && light_hi && temp_hi;
    assign held     = op_reg.temp_valid && (elapsed < cfg.hold_time_ms);

    assign op_ready  = (state_reg == B_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        wp_next        = wp_reg;
        full_next      = full_reg;
        sum_next       = sum_reg;
        last_fire_next = last_fire_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (op_valid)
                begin
                    op_next = op;
                    if (op.kind == OP_STORE)
                    begin
                        state_next = B_STORE_RD;
                    end
                    else if (win_count == '0)
                    begin
                        quo_next   = '0;
                        state_next = B_DECIDE;
                    end
                    else
                    begin
                        dvd_next   = sum_reg;
                        rem_next   = '0;
                        quo_next   = '0;
                        step_next  = SCW'(SW - 1);
                        state_next = B_DIV;
                    end
                end
            end
            B_STORE_RD:
            begin
                // oldest entry lands in rd_data_reg
                state_next = B_STORE_WR;
            end
            B_STORE_WR:
            begin
                mem_we   = 1'b1;
                sum_next = sum_reg - (full_reg ? SW'(rd_data_reg) : '0)
                           + SW'(op_reg.light_sample);
                if (wp_reg == PW'(WINDOW_DEPTH - 1))
                begin
                    wp_next   = '0;
                    full_next = 1'b1;
                end
                else
                begin
                    wp_next = wp_reg + 1'b1;
                end
                state_next = B_IDLE;
            end
            B_DIV:
            begin
                rem_next = rem_ge ? (rem_sh - {1'b0, win_count}) : rem_sh;
                quo_next = {quo_reg[SW-2:0], rem_ge};
                dvd_next = {dvd_reg[SW-2:0], 1'b0};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = B_DECIDE;
                end
            end
            B_DECIDE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load                 = 1'b1;
                    out_data_next.fire       = hit || held;
                    out_data_next.light_mean = quo_reg[LIGHT_W-1:0];
                    if (hit)
                    begin
                        last_fire_next = op_reg.now_ms;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            sum_reg       <= '0;
            last_fire_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            full_reg      <= full_next;
            sum_reg       <= sum_next;
            last_fire_reg <= last_fire_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[wp_reg] <= op_reg.light_sample;
        end
        rd_data_reg <= sample_mem[wp_reg];
    end

    `LAFD_NEVER(a_div_empty, (state_reg == B_DIV) && (win_count == '0), "divide by empty window")
    `LAFD_ASSERT(a_out_free, out_load |-> (!out_valid_reg || out_ready), "result overwritten")
    `LAFD_ASSERT(a_full_wrap, $rose(full_reg) |-> (wp_reg == '0), "window filled off wrap")

endmodule

`default_nettype wire

[hw/rtl/light_average_fire_detector_core.sv]
// Light average fire detector: top level with APB registers
//
// Store beats write a 12-bit light sample into a circular window of
// WINDOW_DEPTH entries; evaluate beats return one result beat with the
// truncated window mean and the fire flag (detection, or still inside the
// hold time after the last detection). A two-beat queue takes input beats
// while the back end works. In the back end a store is taken, then reads
// the oldest entry from the window RAM, then writes the new sample. An
// evaluate is taken, then runs the one-bit-per-cycle divider that forms
// the mean, then decides; with an empty window the division is skipped.
// Registers at byte addresses 0x0 light_threshold, 0x4 temp_threshold,
// 0x8 hold_time_ms; write them only while the block is idle.
`default_nettype none

module light_average_fire_detector_core #(
    parameter int WINDOW_DEPTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire lafd_pkg::in_t                  in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output lafd_pkg::out_t                      out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lafd_pkg::APB_AW-1:0]    paddr,
    input  wire logic [lafd_pkg::APB_DW-1:0]    pwdata,
    output logic [lafd_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import lafd_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_we;
    logic [1:0] reg_idx;
    logic       op_valid;
    logic       op_ready;
    op_t        op;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_idx)
                REG_LIGHT_THR: cfg_next.light_threshold = pwdata[LIGHT_W-1:0];
                REG_TEMP_THR:  cfg_next.temp_threshold  = pwdata[TEMP_W-1:0];
                REG_HOLD_TIME: cfg_next.hold_time_ms    = pwdata[TIME_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LIGHT_THR: prdata = {{(APB_DW - LIGHT_W){1'b0}}, cfg_reg.light_threshold};
            REG_TEMP_THR:  prdata = {{(APB_DW - TEMP_W){cfg_reg.temp_threshold[TEMP_W-1]}},
                                     cfg_reg.temp_threshold};
            REG_HOLD_TIME: prdata = cfg_reg.hold_time_ms;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_threshold <= LIGHT_THR_RESET;
            cfg_reg.temp_threshold  <= TEMP_THR_RESET;
            cfg_reg.hold_time_ms    <= HOLD_TIME_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lafd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    lafd_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
